>>> hw/rtl/pfge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfge_pkg
// Shared constants, codes and the 5x7 font for the page frame store engine.
// ----------------------------------------------------------------------------
package pfge_pkg;

	localparam int PANEL_WIDTH = 128;
	localparam int PANEL_PAGES = 8;
	localparam int STORE_BYTES = PANEL_WIDTH * PANEL_PAGES;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int GLYPH_COLS  = 5;
	localparam int GIDX_W      = $clog2(GLYPH_COLS);

	typedef enum logic [2:0] {
		OP_SET_PIXEL  = 3'd0,
		OP_CLR_PIXEL  = 3'd1,
		OP_DRAW_GLYPH = 3'd2,
		OP_CLR_PAGE   = 3'd3,
		OP_CLR_ALL    = 3'd4,
		OP_READ_BYTE  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RMW,
		ST_RDWAIT,
		ST_GLYPH,
		ST_SWEEP,
		ST_DONE
	} state_t;

	// five column bytes, leftmost column in the low byte
	function automatic logic [39:0] font_glyph(input logic [7:0] code);
		logic [39:0] g;
		g = '0;
		case (code)
			8'h30: g = 40'h3E4549513E; // 0
			8'h31: g = 40'h00407F4200;
			8'h32: g = 40'h4649516142;
			8'h33: g = 40'h314B454121;
			8'h34: g = 40'h107F121418;
			8'h35: g = 40'h3945454527;
			8'h36: g = 40'h3049494A3C;
			8'h37: g = 40'h0305097101;
			8'h38: g = 40'h3649494936;
			8'h39: g = 40'h1E29494906; // 9
			8'h4D: g = 40'h7F020C027F; // M
			8'h52: g = 40'h462919097F; // R
			8'h53: g = 40'h3149494946; // S
			8'h54: g = 40'h01017F0101; // T
			8'h41: g = 40'h7E1111117E; // A
			8'h42: g = 40'h364949497F; // B
			8'h43: g = 40'h224141413E; // C
			8'h44: g = 40'h1C2241417F; // D
			8'h45: g = 40'h414949497F; // E
			8'h48: g = 40'h7F0808087F; // H
			8'h49: g = 40'h00417F4100; // I
			8'h4C: g = 40'h404040407F; // L
			8'h4E: g = 40'h7F0804027F; // N
			8'h4F: g = 40'h3E4141413E; // O
			8'h50: g = 40'h060909097F; // P
			8'h56: g = 40'h1F2040201F; // V
			8'h47: g = 40'h7A4949413E; // G
			8'h55: g = 40'h3F4040403F; // U
			8'h4B: g = 40'h412214087F; // K
			8'h2E: g = 40'h0000606000; // dot
			default: g = '0;
		endcase
		return g;
	endfunction

	function automatic logic [7:0] font_column(input logic [7:0] code,
	                                            input logic [GIDX_W-1:0] idx);
		logic [39:0] g;
		logic [7:0]  c;
		g = font_glyph(code);
		case (idx)
			GIDX_W'(0): c = g[7:0];
			GIDX_W'(1): c = g[15:8];
			GIDX_W'(2): c = g[23:16];
			GIDX_W'(3): c = g[31:24];
			GIDX_W'(4): c = g[39:32];
			default:    c = '0;
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/pfge_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfge_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pfge_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> hw/rtl/page_framebuffer_glyph_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_glyph_engine_unit
// Monochrome page frame store with pixel, glyph, clear and read operations.
// ----------------------------------------------------------------------------
// Usage:
//   One operation enters per s_axis transaction; every operation returns one
//   m_axis transaction carrying read_data (the column byte for a read, zero
//   otherwise). The store is one single-port RAM of PANEL_WIDTH*PANEL_PAGES
//   bytes, page-major, bit 0 the top pixel of a page.
//   Steps from accept to result valid, all bound by the one RAM port:
//     set/clear pixel, read byte: read, modify-write or capture, result
//     draw glyph: five column writes, result
//     clear page: PANEL_WIDTH bytes, clear all: STORE_BYTES bytes (one byte a cycle)
//     out-of-range or unused op: straight to the result
//   One item is worked at a time; the next is accepted in the cycle after the
//   previous one has reached the output register, even if that result is still
//   waiting. Reset: the RAM is swept to zero, all STORE_BYTES bytes (1024 by
//   default), with s_axis_tready low. A stalled receiver holds the result in
//   the output register; the engine finishes the next item and then waits for
//   room.
// ----------------------------------------------------------------------------
module page_framebuffer_glyph_engine_unit
	import pfge_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[2:0], column[9:3], row[15:10], page_index[18:16], char_code[26:19]
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[7:0]
	output logic [7:0]  m_axis_tdata
);

	state_t state_q, state_d;

	op_t              op_q;
	logic [6:0]       col_q;
	logic [5:0]       row_q;
	logic [2:0]       page_q;
	logic [7:0]       code_q;

	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [ADDR_W-1:0] end_q, end_d;
	logic [GIDX_W-1:0] gidx_q, gidx_d;
	logic [7:0]        result_q, result_d;
	logic              out_valid_q;
	logic [7:0]        out_data_q;
	logic              load_out;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;

	logic              in_accept;
	logic              pix_ok, page_ok, rd_ok, gcol_ok;
	logic [ADDR_W-1:0] pix_addr, rd_addr, page_base, gcol_addr;
	logic [7:0]        pix_mask;
	int unsigned       gcol;

	pfge_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign in_accept = s_axis_tvalid && s_axis_tready;

	// address and range decode of the latched item
	assign pix_ok    = (32'(col_q) < PANEL_WIDTH) && (32'(row_q) < 8 * PANEL_PAGES);
	assign pix_addr  = ADDR_W'(32'(row_q[5:3]) * PANEL_WIDTH + 32'(col_q));
	assign pix_mask  = 8'(1) << row_q[2:0];
	assign page_ok   = 32'(page_q) < PANEL_PAGES;
	assign rd_ok     = page_ok && (32'(col_q) < PANEL_WIDTH);
	assign page_base = ADDR_W'(32'(page_q) * PANEL_WIDTH);
	assign rd_addr   = ADDR_W'(32'(page_q) * PANEL_WIDTH + 32'(col_q));
	assign gcol      = 32'(col_q) + 32'(gidx_q);
	assign gcol_ok   = gcol < PANEL_WIDTH;
	assign gcol_addr = ADDR_W'(32'(page_q) * PANEL_WIDTH + gcol);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			addr_q      <= '0;
			end_q       <= ADDR_W'(STORE_BYTES - 1);
			gidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			end_q   <= end_d;
			gidx_q  <= gidx_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		if (in_accept) begin
			op_q   <= op_t'(s_axis_tdata[2:0]);
			col_q  <= s_axis_tdata[9:3];
			row_q  <= s_axis_tdata[15:10];
			page_q <= s_axis_tdata[18:16];
			code_q <= s_axis_tdata[26:19];
		end
		if (load_out) begin
			out_data_q <= result_q;
		end
	end

	always_comb begin
		state_d       = state_q;
		addr_d        = addr_q;
		end_d         = end_q;
		gidx_d        = gidx_q;
		result_d      = result_q;
		ram_we        = 1'b0;
		ram_addr      = addr_q;
		ram_wdata     = '0;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
				if (addr_q == end_q) begin
					state_d = ST_IDLE;
				end else begin
					addr_d = addr_q + ADDR_W'(1);
				end
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				result_d = '0;
				gidx_d   = '0;
				state_d  = ST_DONE;
				case (op_q)
					OP_SET_PIXEL, OP_CLR_PIXEL: begin
						if (pix_ok) begin
							ram_addr = pix_addr;
							addr_d   = pix_addr;
							state_d  = ST_RMW;
						end
					end
					OP_DRAW_GLYPH: begin
						if (page_ok) begin
							state_d = ST_GLYPH;
						end
					end
					OP_CLR_PAGE: begin
						if (page_ok) begin
							addr_d  = page_base;
							end_d   = page_base + ADDR_W'(PANEL_WIDTH - 1);
							state_d = ST_SWEEP;
						end
					end
					OP_CLR_ALL: begin
						addr_d  = '0;
						end_d   = ADDR_W'(STORE_BYTES - 1);
						state_d = ST_SWEEP;
					end
					OP_READ_BYTE: begin
						if (rd_ok) begin
							ram_addr = rd_addr;
							state_d  = ST_RDWAIT;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_RMW: begin
				ram_we    = 1'b1;
				ram_wdata = (op_q == OP_SET_PIXEL) ? (ram_rdata | pix_mask)
				                                   : (ram_rdata & ~pix_mask);
				state_d   = ST_DONE;
			end
			ST_RDWAIT: begin
				result_d = ram_rdata;
				state_d  = ST_DONE;
			end
			ST_GLYPH: begin
				// columns past the right edge are dropped
				ram_we    = gcol_ok;
				ram_addr  = gcol_addr;
				ram_wdata = font_column(code_q, gidx_q);
				gidx_d    = gidx_q + GIDX_W'(1);
				if (gidx_q == GIDX_W'(GLYPH_COLS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_SWEEP: begin
				ram_we = 1'b1;
				if (addr_q == end_q) begin
					state_d = ST_DONE;
				end else begin
					addr_d = addr_q + ADDR_W'(1);
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// only a read transaction can return a nonzero byte
	a_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && op_q != OP_READ_BYTE |-> result_q == 8'd0)
		else $error("nonzero result for a non-read operation");

	// the reset sweep only writes zeros and holds off input
	a_init_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT |-> ram_we && ram_wdata == 8'd0 && !s_axis_tready)
		else $error("reset sweep misbehaves");

	// glyph writes never land past the right edge of the page
	a_glyph_clip: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GLYPH && ram_we |-> gcol < PANEL_WIDTH)
		else $error("glyph write beyond panel width");

	// an accepted item always starts execution next
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_EXEC)
		else $error("accepted item not executed");

	// a result is only loaded when the output register has room
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || m_axis_tready)
		else $error("output register overwritten");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page frame store and glyph engine. A queue of
// operations feeds a stream driver with random gaps. A monitor keeps a shadow
// frame store, predicts every result byte and compares it with the output.
// The receiver stalls at random and once holds off long enough for the block
// to back up its input.
// ----------------------------------------------------------------------------
module tb;
	import pfge_pkg::*;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam int         RANDOM_OPS = 680;
	localparam string      FONT_CHARS = "0123456789MRSTABCDEHILNOPVGUK.";

	// one operation as it sits in tdata, lowest field last
	typedef struct packed {
		logic [7:0] char_code;
		logic [2:0] page_index;
		logic [5:0] row;
		logic [6:0] column;
		logic [2:0] op;
	} pixel_cmd_t;

	// glyph columns, index 0 is the leftmost
	typedef logic [0:4][7:0] glyph_cols_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;

	pixel_cmd_t  pending_cmds [$];
	int          pending_gaps [$];
	logic [7:0]  expected_bytes [$];
	logic [7:0]  shadow_frame [0:STORE_BYTES-1];

	logic        in_taken = 1'b0;
	logic        out_taken = 1'b0;
	int          tx_wait = 0;
	int          rx_wait = 0;
	int          hold_left = 0;
	bit          pressure_done = 1'b0;

	int          total_cmds = 0;
	int          cmds_taken = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          op_hits [0:7];
	int          nonzero_reads = 0;
	int          clipped_glyphs = 0;

	page_framebuffer_glyph_engine_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	function automatic glyph_cols_t font_bitmap(input logic [7:0] code);
		glyph_cols_t g;
		case (code)
			8'h30: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}; // digits
			8'h31: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
			8'h32: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
			8'h33: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
			8'h34: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
			8'h35: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
			8'h36: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
			8'h37: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
			8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
			8'h39: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
			8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}; // M
			8'h52: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46}; // R
			8'h53: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31}; // S
			8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01}; // T
			8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}; // A
			8'h42: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36}; // B
			8'h43: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}; // C
			8'h44: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C}; // D
			8'h45: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}; // E
			8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F}; // H
			8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}; // I
			8'h4C: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40}; // L
			8'h4E: g = {8'h7F, 8'h02, 8'h04, 8'h08, 8'h7F}; // N
			8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}; // O
			8'h50: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06}; // P
			8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F}; // V
			8'h47: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}; // G
			8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}; // U
			8'h4B: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}; // K
			8'h2E: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00}; // dot
			default: g = '0;
		endcase
		return g;
	endfunction

	// applies one operation to the shadow store and returns the result byte
	function automatic logic [7:0] draw_and_fetch(input pixel_cmd_t c);
		logic [7:0]  fetched;
		glyph_cols_t g;
		int          base;
		int          cell_addr;
		fetched = '0;
		base = int'(c.page_index) * PANEL_WIDTH;
		cell_addr = int'(c.row[5:3]) * PANEL_WIDTH + int'(c.column);
		case (c.op)
			OP_SET_PIXEL:  shadow_frame[cell_addr][c.row[2:0]] = 1'b1;
			OP_CLR_PIXEL:  shadow_frame[cell_addr][c.row[2:0]] = 1'b0;
			OP_DRAW_GLYPH: begin
				g = font_bitmap(c.char_code);
				// columns past the right edge are dropped, never wrapped
				for (int i = 0; i < GLYPH_COLS; i++) begin
					if (int'(c.column) + i < PANEL_WIDTH)
						shadow_frame[base + int'(c.column) + i] = g[i];
				end
			end
			OP_CLR_PAGE: begin
				for (int i = 0; i < PANEL_WIDTH; i++)
					shadow_frame[base + i] = '0;
			end
			OP_CLR_ALL: begin
				for (int i = 0; i < STORE_BYTES; i++)
					shadow_frame[i] = '0;
			end
			OP_READ_BYTE: fetched = shadow_frame[base + int'(c.column)];
			default: fetched = '0;
		endcase
		return fetched;
	endfunction

	task automatic flag_mismatch(input string what, input logic [7:0] got,
	                             input logic [7:0] want);
		if (mismatches < 40)
			$display("[%0t] MISMATCH %s: got 0x%02h, want 0x%02h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic push_cmd(input logic [2:0] op, input int column, input int row,
	                        input int page_index, input int char_code);
		pixel_cmd_t c;
		c.op = op;
		c.column = 7'(column);
		c.row = 6'(row);
		c.page_index = 3'(page_index);
		c.char_code = 8'(char_code);
		pending_cmds.push_back(c);
		// a stretch of back-to-back transactions every 200 operations
		if ((total_cmds % 200) >= 100 && (total_cmds % 200) < 150)
			pending_gaps.push_back(0);
		else
			pending_gaps.push_back($urandom_range(0, 9));
		total_cmds++;
	endtask

	// driver: next operation goes out once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (tx_wait > 0) begin
				s_axis_tvalid <= 1'b0;
				tx_wait <= tx_wait - 1;
			end else if (pending_cmds.size() > 0) begin
				s_axis_tdata <= 32'(pending_cmds.pop_front());
				tx_wait <= pending_gaps.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, quiet stretches, and one long hold-off
	always @(negedge clk) begin
		int w;
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (out_taken) begin
			if (!pressure_done && results_seen >= 300) begin
				pressure_done <= 1'b1;
				hold_left <= 400;
				m_axis_tready <= 1'b0;
			end else begin
				w = ((results_seen % 200) < 50) ? 0 : $urandom_range(0, 9);
				m_axis_tready <= (w == 0);
				rx_wait <= (w > 0) ? w - 1 : 0;
			end
		end else if (rx_wait > 0) begin
			m_axis_tready <= 1'b0;
			rx_wait <= rx_wait - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor: check results, then predict for a newly taken operation
	always @(posedge clk) begin
		pixel_cmd_t c;
		logic [7:0] want;
		in_taken <= s_axis_tvalid && s_axis_tready;
		out_taken <= m_axis_tvalid && m_axis_tready;
		if (m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (expected_bytes.size() == 0) begin
				flag_mismatch("result transaction with nothing pending", m_axis_tdata, 8'h00);
			end else begin
				want = expected_bytes.pop_front();
				if (m_axis_tdata !== want)
					flag_mismatch("read_data", m_axis_tdata, want);
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			c = pixel_cmd_t'(s_axis_tdata[26:0]);
			want = draw_and_fetch(c);
			expected_bytes.push_back(want);
			cmds_taken++;
			op_hits[c.op]++;
			if (c.op == OP_READ_BYTE && want != 8'h00)
				nonzero_reads++;
			if (c.op == OP_DRAW_GLYPH && int'(c.column) + GLYPH_COLS > PANEL_WIDTH)
				clipped_glyphs++;
		end
	end

	initial begin
		#8_000_000;
		$display("TIMEOUT with %0d results outstanding", expected_bytes.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		pixel_cmd_t c;
		for (int i = 0; i < STORE_BYTES; i++)
			shadow_frame[i] = '0;
		for (int i = 0; i < 8; i++)
			op_hits[i] = 0;

		// directed: corners, every op, clipping, unknown glyph, spare codes
		push_cmd(OP_READ_BYTE, 0, 0, 0, 0);
		push_cmd(OP_SET_PIXEL, 0, 0, 0, 0);
		push_cmd(OP_SET_PIXEL, 127, 63, 7, 255);
		push_cmd(OP_READ_BYTE, 0, 63, 0, 255);
		push_cmd(OP_READ_BYTE, 127, 0, 7, 0);
		push_cmd(OP_SET_PIXEL, 127, 62, 0, 0);
		push_cmd(OP_CLR_PIXEL, 127, 63, 7, 0);
		push_cmd(OP_READ_BYTE, 127, 0, 7, 0);
		push_cmd(OP_DRAW_GLYPH, 10, 0, 0, 8'h30);
		push_cmd(OP_READ_BYTE, 12, 0, 0, 0);
		push_cmd(OP_DRAW_GLYPH, 125, 0, 7, 8'h4D);
		push_cmd(OP_READ_BYTE, 127, 0, 7, 0);
		push_cmd(OP_READ_BYTE, 0, 0, 0, 0);
		push_cmd(OP_DRAW_GLYPH, 60, 0, 3, 8'h2E);
		push_cmd(OP_DRAW_GLYPH, 61, 0, 3, 8'hFF);
		push_cmd(OP_READ_BYTE, 60, 0, 3, 0);
		push_cmd(OP_READ_BYTE, 61, 0, 3, 0);
		push_cmd(OP_SPARE_A, 127, 63, 7, 255);
		push_cmd(OP_SPARE_B, 5, 1, 2, 8'h41);
		push_cmd(OP_CLR_PAGE, 127, 63, 7, 255);
		push_cmd(OP_READ_BYTE, 126, 0, 7, 0);
		push_cmd(OP_CLR_ALL, 3, 3, 3, 3);
		push_cmd(OP_READ_BYTE, 10, 0, 0, 0);
		push_cmd(OP_READ_BYTE, 0, 0, 0, 0);

		// random: mostly drawing and reading back a small hot area
		for (int n = 0; n < RANDOM_OPS; n++) begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 20)       c.op = OP_SET_PIXEL;
			else if (r < 30)  c.op = OP_CLR_PIXEL;
			else if (r < 48)  c.op = OP_DRAW_GLYPH;
			else if (r < 85)  c.op = OP_READ_BYTE;
			else if (r < 90)  c.op = OP_CLR_PAGE;
			else if (r < 91)  c.op = OP_CLR_ALL;
			else if (r < 93)  c.op = OP_SPARE_A;
			else if (r < 94)  c.op = OP_SPARE_B;
			else              c.op = OP_READ_BYTE;
			c.column = 7'($urandom_range(0, 127));
			c.row = 6'($urandom_range(0, 63));
			c.page_index = 3'($urandom_range(0, 7));
			c.char_code = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 1)) begin
				c.column = 7'($urandom_range(0, 15));
				c.row = 6'($urandom_range(0, 15));
				c.page_index = 3'($urandom_range(0, 1));
			end
			if (c.op == OP_DRAW_GLYPH) begin
				if ($urandom_range(0, 3) == 0)
					c.column = 7'($urandom_range(120, 127));
				if ($urandom_range(0, 9) < 6)
					c.char_code = FONT_CHARS[$urandom_range(0, FONT_CHARS.len() - 1)];
			end
			push_cmd(c.op, c.column, c.row, c.page_index, c.char_code);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmds_taken < total_cmds || expected_bytes.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("ran %0d operations: set %0d, clear %0d, glyph %0d, page clear %0d, full clear %0d",
		         cmds_taken, op_hits[OP_SET_PIXEL], op_hits[OP_CLR_PIXEL],
		         op_hits[OP_DRAW_GLYPH], op_hits[OP_CLR_PAGE], op_hits[OP_CLR_ALL]);
		$display("reads %0d (%0d nonzero), spare ops %0d, glyphs clipped at edge %0d",
		         op_hits[OP_READ_BYTE], nonzero_reads, op_hits[OP_SPARE_A] + op_hits[OP_SPARE_B],
		         clipped_glyphs);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
